### rtl/qau_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, opcodes, saturation helper and the divider/root stage type.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int DW   = 32;          // component width
  localparam int FB   = 28;          // fraction bits
  localparam int PW   = 2 * DW;      // full product width
  localparam int SW   = PW + 1;      // squared-norm sum width
  localparam int HW   = PW + 2;      // sum of four products
  localparam int SATW = HW - FB;     // rounded sum before saturation
  localparam int NQW  = SW - FB;     // rounded squared norm (divisor)
  localparam int QW   = DW + 1;      // quotient bits per lane
  localparam int NW   = DW + FB;     // reciprocal numerator width
  localparam int NHI  = NW - QW;     // numerator bits above the quotient
  localparam int RTW  = DW - 1;      // square root bits
  localparam int RAW  = 2 * RTW;     // radicand bits
  localparam int SRW  = DW + 1;      // square root remainder

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_NEG,
    OP_CONJ,
    OP_NSQ,
    OP_NORM,
    OP_RECIP
  } op_e;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
  } sat_t;

  typedef struct packed {
    op_e                 op;
    logic [3:0][DW-1:0]  r;
    logic                ovf;
    logic                dz;
    logic [3:0]          neg;
    logic [3:0]          dov;
    logic                sqov;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [NQW-1:0]      d;
    logic [3:0][NQW-1:0] rem;
    logic [3:0][QW-1:0]  num;
    logic [3:0][QW-1:0]  quo;
    logic [RAW-1:0]      rad;
    logic [SRW-1:0]      srem;
    logic [RTW-1:0]      root;
  } it_t;

  // Clamp a signed value to the component range.
  function automatic sat_t sat_s(input logic [SATW-1:0] v);
    sat_t s;
    if ((&v[SATW-1:DW-1]) || !(|v[SATW-1:DW-1])) begin
      s.val = v[DW-1:0];
      s.ovf = 1'b0;
    end else begin
      s.val = v[SATW-1] ? SMIN : SMAX;
      s.ovf = 1'b1;
    end
    return s;
  endfunction

endpackage

### rtl/qau_iter.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit: divider and square root pipeline
// One quotient bit per lane per stage and one root bit in each of the first RTW stages, restoring form.
// ----------------------------------------------------------------------------
module qau_iter import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  it_t  data_i,
  output logic valid_o,
  output it_t  data_o
);

  it_t        st_d [QW];
  it_t        st_q [QW];
  logic [QW-1:0] v_q;

  function automatic it_t step(input it_t x, input logic sq_en);
    it_t y;
    logic [NQW:0]   r2;
    logic [NQW:0]   df;
    logic [SRW+1:0] t;
    logic [SRW+1:0] trial;
    logic [SRW+1:0] sd;
    y = x;
    for (int n = 0; n < 4; n++) begin
      r2 = {x.rem[n], x.num[n][QW-1]};
      df = r2 - {1'b0, x.d};
      y.num[n] = {x.num[n][QW-2:0], 1'b0};
      if (r2 >= {1'b0, x.d}) begin
        y.rem[n] = df[NQW-1:0];
        y.quo[n] = {x.quo[n][QW-2:0], 1'b1};
      end else begin
        y.rem[n] = r2[NQW-1:0];
        y.quo[n] = {x.quo[n][QW-2:0], 1'b0};
      end
    end
    if (sq_en) begin
      t     = {x.srem, x.rad[RAW-1:RAW-2]};
      trial = {2'b00, x.root, 2'b01};
      sd    = t - trial;
      y.rad = {x.rad[RAW-3:0], 2'b00};
      if (t >= trial) begin
        y.srem = sd[SRW-1:0];
        y.root = {x.root[RTW-2:0], 1'b1};
      end else begin
        y.srem = t[SRW-1:0];
        y.root = {x.root[RTW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  always_comb begin
    st_d[0] = step(data_i, 1'b1);
    for (int k = 1; k < QW; k++) begin
      st_d[k] = step(st_q[k-1], k < RTW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) st_q[k] <= st_d[k];
    end
  end

  assign valid_o = v_q[QW-1];
  assign data_o  = st_q[QW-1];

endmodule

### rtl/quaternion_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Most of the path to out_valid_o is the 33-stage divider pipeline.
// Throughput: one item per cycle, unless a stalled output has filled
// the skid stage, which also keeps in_ready_o registered.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic signed [DW-1:0] a_real_i,
  input  logic signed [DW-1:0] a_i_i,
  input  logic signed [DW-1:0] a_j_i,
  input  logic signed [DW-1:0] a_k_i,
  input  logic signed [DW-1:0] b_real_i,
  input  logic signed [DW-1:0] b_i_i,
  input  logic signed [DW-1:0] b_j_i,
  input  logic signed [DW-1:0] b_k_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DW-1:0] r_real_o,
  output logic signed [DW-1:0] r_i_o,
  output logic signed [DW-1:0] r_j_o,
  output logic signed [DW-1:0] r_k_o,
  output logic                 overflow_o,
  output logic                 divide_by_zero_o
);

  logic en;

  // stage 1: operands
  op_e                s1_op_q;
  logic [3:0][DW-1:0] s1_a_q, s1_b_q;
  logic               s1_v_q;

  // stage 2: products and simple operations
  logic signed [PW-1:0] s2_p_d [4][4];
  logic signed [PW-1:0] s2_p_q [4][4];
  logic [PW-1:0]        s2_sq_d [4];
  logic [PW-1:0]        s2_sq_q [4];
  logic [3:0][DW-1:0]   s2_r_d, s2_r_q;
  logic                 s2_ovf_d, s2_ovf_q;
  op_e                  s2_op_q;
  logic [3:0][DW-1:0]   s2_a_q;
  logic                 s2_v_q;

  // stage 3: pair sums
  logic signed [PW:0]   s3_h0_d [4];
  logic signed [PW:0]   s3_h1_d [4];
  logic signed [PW:0]   s3_h0_q [4];
  logic signed [PW:0]   s3_h1_q [4];
  logic [PW-1:0]        s3_s1_q, s3_s2_q;
  logic [3:0][DW-1:0]   s3_r_q, s3_a_q;
  logic                 s3_ovf_q;
  op_e                  s3_op_q;
  logic                 s3_v_q;

  // stage 4: full sums
  logic [3:0][HW-1:0]   s4_hs_q;
  logic [SW-1:0]        s4_tot_q, s4_nqr_q;
  logic [3:0][DW-1:0]   s4_r_q, s4_a_q;
  logic                 s4_ovf_q;
  op_e                  s4_op_q;
  logic                 s4_v_q;

  // stage 5: rounding, saturation, divider operands
  logic [NQW-1:0]       nq_w;
  logic [3:0][DW-1:0]   s5_r_d, s5_r_q;
  logic                 s5_ovf_d, s5_ovf_q;
  logic [3:0]           s5_neg_d, s5_neg_q;
  logic [3:0][NW-1:0]   s5_n_d, s5_n_q;
  logic [NQW-1:0]       s5_d_q;
  logic                 s5_dz_q, s5_sqov_q;
  logic [RAW-1:0]       s5_rad_q;
  op_e                  s5_op_q;
  logic                 s5_v_q;

  // stage 6: divider set-up
  it_t                  s6_d, s6_q;
  logic                 s6_v_q;

  it_t                  it_x;
  logic                 it_v;

  logic [3:0][DW-1:0]   fin_r;
  logic                 fin_ovf, fin_dz;
  logic                 inc_v;

  logic [3:0][DW-1:0]   out_r_q, skid_r_q;
  logic                 out_ovf_q, out_dz_q, skid_ovf_q, skid_dz_q;
  logic                 out_v_q, skid_v_q;

  function automatic logic signed [PW:0] sx(input logic signed [PW-1:0] p);
    return {p[PW-1], p};
  endfunction

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [DW:0] ea;
    logic signed [DW:0] eb;
    logic signed [DW:0] v;
    sat_t               s;
    s2_ovf_d = 1'b0;
    for (int m = 0; m < 4; m++) begin
      for (int n = 0; n < 4; n++) begin
        s2_p_d[m][n] = $signed(s1_a_q[m]) * $signed(s1_b_q[n]);
      end
      s2_sq_d[m] = $signed(s1_a_q[m]) * $signed(s1_a_q[m]);
      ea = {s1_a_q[m][DW-1], s1_a_q[m]};
      eb = {s1_b_q[m][DW-1], s1_b_q[m]};
      case (s1_op_q)
        OP_ADD:  v = ea + eb;
        OP_SUB:  v = ea - eb;
        OP_NEG:  v = -ea;
        OP_CONJ: v = (m == 0) ? ea : -ea;
        default: v = '0;
      endcase
      s = sat_s({{(SATW-DW-1){v[DW]}}, v});
      s2_r_d[m] = s.val;
      s2_ovf_d  = s2_ovf_d | s.ovf;
    end
  end

  always_comb begin
    s3_h0_d[0] = sx(s2_p_q[0][0]) - sx(s2_p_q[1][1]);
    s3_h1_d[0] = -sx(s2_p_q[2][2]) - sx(s2_p_q[3][3]);
    s3_h0_d[1] = sx(s2_p_q[0][1]) + sx(s2_p_q[1][0]);
    s3_h1_d[1] = sx(s2_p_q[2][3]) - sx(s2_p_q[3][2]);
    s3_h0_d[2] = sx(s2_p_q[0][2]) + sx(s2_p_q[2][0]);
    s3_h1_d[2] = sx(s2_p_q[3][1]) - sx(s2_p_q[1][3]);
    s3_h0_d[3] = sx(s2_p_q[0][3]) + sx(s2_p_q[1][2]);
    s3_h1_d[3] = sx(s2_p_q[3][0]) - sx(s2_p_q[2][1]);
  end

  assign nq_w = s4_nqr_q[SW-1:FB];

  always_comb begin
    sat_t          s;
    logic [DW-1:0] m;
    s5_r_d   = s4_r_q;
    s5_ovf_d = s4_ovf_q;
    case (s4_op_q)
      OP_MUL: begin
        s5_ovf_d = 1'b0;
        for (int n = 0; n < 4; n++) begin
          s = sat_s(s4_hs_q[n][HW-1:FB]);
          s5_r_d[n] = s.val;
          s5_ovf_d  = s5_ovf_d | s.ovf;
        end
      end
      OP_NSQ: begin
        s5_r_d = '0;
        if (|nq_w[NQW-1:DW-1]) begin
          s5_r_d[0] = SMAX;
          s5_ovf_d  = 1'b1;
        end else begin
          s5_r_d[0] = nq_w[DW-1:0];
          s5_ovf_d  = 1'b0;
        end
      end
      default: ;
    endcase
    // reciprocal works on the conjugate: the imaginary parts change sign
    for (int n = 0; n < 4; n++) begin
      if (n == 0) begin
        s5_neg_d[n] = s4_a_q[n][DW-1];
      end else begin
        s5_neg_d[n] = !s4_a_q[n][DW-1] && (|s4_a_q[n]);
      end
      m = s4_a_q[n][DW-1] ? -s4_a_q[n] : s4_a_q[n];
      s5_n_d[n] = {m, {FB{1'b0}}} + NW'(nq_w[NQW-1:1]);
    end
  end

  always_comb begin
    logic [NQW-1:0] hi;
    s6_d.side.op   = s5_op_q;
    s6_d.side.r    = s5_r_q;
    s6_d.side.ovf  = s5_ovf_q;
    s6_d.side.dz   = s5_dz_q;
    s6_d.side.neg  = s5_neg_q;
    s6_d.side.sqov = s5_sqov_q;
    s6_d.d         = s5_d_q;
    s6_d.quo       = '0;
    s6_d.rad       = s5_rad_q;
    s6_d.srem      = '0;
    s6_d.root      = '0;
    for (int n = 0; n < 4; n++) begin
      hi = {{(NQW-NHI){1'b0}}, s5_n_q[n][NW-1:QW]};
      // quotient would need more than QW bits: flag it and keep the lane idle
      s6_d.side.dov[n] = (hi >= s5_d_q);
      s6_d.rem[n]      = s6_d.side.dov[n] ? '0 : hi;
      s6_d.num[n]      = s5_n_q[n][QW-1:0];
    end
  end

  qau_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_v_q),
    .data_i  (s6_q),
    .valid_o (it_v),
    .data_o  (it_x)
  );

  always_comb begin
    logic [DW-1:0] q_n;
    logic [QW-1:0] qd;
    logic [QW-1:0] qneg;
    logic          big;
    fin_r   = it_x.side.r;
    fin_ovf = it_x.side.ovf;
    fin_dz  = 1'b0;
    case (it_x.side.op)
      OP_NORM: begin
        // round to nearest: bump when the remainder exceeds the root
        q_n   = {1'b0, it_x.root} + DW'(it_x.srem > {2'b00, it_x.root});
        fin_r = '0;
        if (it_x.side.sqov || q_n[DW-1]) begin
          fin_r[0] = SMAX;
          fin_ovf  = 1'b1;
        end else begin
          fin_r[0] = q_n;
          fin_ovf  = 1'b0;
        end
      end
      OP_RECIP: begin
        fin_r   = '0;
        fin_ovf = 1'b0;
        fin_dz  = it_x.side.dz;
        if (!it_x.side.dz) begin
          for (int n = 0; n < 4; n++) begin
            qd   = it_x.quo[n];
            qneg = -qd;
            if (it_x.side.neg[n]) begin
              big = it_x.side.dov[n] || qd[QW-1] || (qd[DW-1] && (|qd[DW-2:0]));
              fin_r[n] = big ? SMIN : qneg[DW-1:0];
            end else begin
              big = it_x.side.dov[n] || qd[QW-1] || qd[DW-1];
              fin_r[n] = big ? SMAX : qd[DW-1:0];
            end
            fin_ovf = fin_ovf | big;
          end
        end
      end
      default: ;
    endcase
  end

  assign inc_v = en && it_v;

  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s5_v_q   <= 1'b0;
      s6_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        s1_v_q <= in_valid_i;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        s4_v_q <= s3_v_q;
        s5_v_q <= s4_v_q;
        s6_v_q <= s5_v_q;
      end
      if (!out_v_q || out_ready_i) begin
        out_v_q  <= skid_v_q || inc_v;
        skid_v_q <= 1'b0;
      end else if (inc_v) begin
        // output stalled: park the leaving result and hold the pipe
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= op_e'(mode_i);
      s1_a_q  <= {a_k_i, a_j_i, a_i_i, a_real_i};
      s1_b_q  <= {b_k_i, b_j_i, b_i_i, b_real_i};

      s2_p_q   <= s2_p_d;
      s2_sq_q  <= s2_sq_d;
      s2_r_q   <= s2_r_d;
      s2_ovf_q <= s2_ovf_d;
      s2_op_q  <= s1_op_q;
      s2_a_q   <= s1_a_q;

      s3_h0_q  <= s3_h0_d;
      s3_h1_q  <= s3_h1_d;
      s3_s1_q  <= s2_sq_q[0] + s2_sq_q[1];
      s3_s2_q  <= s2_sq_q[2] + s2_sq_q[3];
      s3_r_q   <= s2_r_q;
      s3_a_q   <= s2_a_q;
      s3_ovf_q <= s2_ovf_q;
      s3_op_q  <= s2_op_q;

      for (int n = 0; n < 4; n++) begin
        s4_hs_q[n] <= {s3_h0_q[n][PW], s3_h0_q[n]} + {s3_h1_q[n][PW], s3_h1_q[n]}
                    + (HW'(1) << (FB - 1));
      end
      s4_tot_q <= {1'b0, s3_s1_q} + {1'b0, s3_s2_q};
      s4_nqr_q <= {1'b0, s3_s1_q} + {1'b0, s3_s2_q} + (SW'(1) << (FB - 1));
      s4_r_q   <= s3_r_q;
      s4_a_q   <= s3_a_q;
      s4_ovf_q <= s3_ovf_q;
      s4_op_q  <= s3_op_q;

      s5_r_q    <= s5_r_d;
      s5_ovf_q  <= s5_ovf_d;
      s5_neg_q  <= s5_neg_d;
      s5_n_q    <= s5_n_d;
      s5_d_q    <= nq_w;
      s5_dz_q   <= (s4_op_q == OP_RECIP) && (nq_w == '0);
      s5_sqov_q <= |s4_tot_q[SW-1:RAW];
      s5_rad_q  <= s4_tot_q[RAW-1:0];
      s5_op_q   <= s4_op_q;

      s6_q <= s6_d;
    end

    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_r_q   <= skid_r_q;
        out_ovf_q <= skid_ovf_q;
        out_dz_q  <= skid_dz_q;
      end else begin
        out_r_q   <= fin_r;
        out_ovf_q <= fin_ovf;
        out_dz_q  <= fin_dz;
      end
    end else if (inc_v) begin
      skid_r_q   <= fin_r;
      skid_ovf_q <= fin_ovf;
      skid_dz_q  <= fin_dz;
    end
  end

  assign out_valid_o      = out_v_q;
  assign r_real_o         = out_r_q[0];
  assign r_i_o            = out_r_q[1];
  assign r_j_o            = out_r_q[2];
  assign r_k_o            = out_r_q[3];
  assign overflow_o       = out_ovf_q;
  assign divide_by_zero_o = out_dz_q;

endmodule
